// ===== hdl/sti_pkg.sv =====
// Shared constants, payload types and sine table builder for the sine table interpolator.
// No dependencies; every other file imports this package.
package sti_pkg;

    localparam int TABLE_SIZE   = 512;
    localparam int IDX_W        = $clog2(TABLE_SIZE);
    localparam int ROM_AW       = $clog2(TABLE_SIZE + 1);
    localparam int FRAC_W       = 56;
    localparam int POS_W        = 40 + IDX_W;
    localparam int WEIGHT_W     = 24;
    localparam int PROD_W       = 32 + WEIGHT_W + 1;
    localparam int TAYLOR_TERMS = 20;

    localparam logic [29:0]         INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic signed [31:0]  SINE_ONE       = 32'sd1073741824;
    localparam logic [WEIGHT_W:0]   WEIGHT_ONE     = (WEIGHT_W + 1)'(1) << WEIGHT_W;
    localparam logic [PROD_W-1:0]   ROUND_HALF     = PROD_W'(1) << (WEIGHT_W - 1);

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] ROM_DEN  = 64'(2 * TABLE_SIZE);
    localparam logic [63:0] PI_STEP  = PI_Q60 / ROM_DEN;
    localparam logic [63:0] PI_REM   = PI_Q60 % ROM_DEN;

    typedef logic signed [31:0] sine_t;
    typedef sine_t sin_rom_t [0:TABLE_SIZE];

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [WEIGHT_W-1:0] weight;
        logic [31:0]         turns;
    } lookup_t;

    typedef struct packed {
        sine_t               lo;
        sine_t               hi;
        logic [WEIGHT_W-1:0] weight;
        logic [31:0]         turns;
    } pair_t;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // floor(num / den) by shift and subtract; used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(2*pi*i/TABLE_SIZE) in Q1.30: fold to the first quadrant, Taylor series in Q60
    function automatic sine_t rom_entry(input int unsigned i);
        logic [63:0]        q;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        div;
        logic [63:0]        r;
        logic [31:0]        rv;
        logic signed [63:0] sum;
        logic               neg;
        q   = (i >= TABLE_SIZE) ? 64'd0 : 64'(i) * 64'd4;
        neg = 1'b0;
        if (q >= ROM_DEN)
        begin
            neg = 1'b1;
            q   = q - ROM_DEN;
        end
        if (q > 64'(TABLE_SIZE))
            q = ROM_DEN - q;
        x    = PI_STEP * q + udiv64(PI_REM * q, ROM_DEN);
        x2   = mul_q60(x, x);
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            if (term != 64'd0)
            begin
                div  = 64'(2 * k) * 64'(2 * k + 1);
                term = udiv64(mul_q60(term, x2), div);
                if ((k & 1) != 0)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
        end
        if (sum < 0)
            sum = 64'sd0;
        r = (64'(sum) + 64'd536870912) >> 30;
        if (r > 64'd1073741824)
            r = 64'd1073741824;
        rv = r[31:0];
        return neg ? -$signed(rv) : $signed(rv);
    endfunction

    function automatic sin_rom_t build_sin_rom();
        sin_rom_t rom;
        for (int i = 0; i <= TABLE_SIZE; i++)
            rom[i] = rom_entry(i);
        return rom;
    endfunction

endpackage

// ===== hdl/sti_turn.sv =====
// Stages 1 and 2: scale radians to turns, keep the fractional turn, split it into
// table index, interpolation weight and wrapped Q31 angle. Depends on sti_pkg.
module sti_turn
    import sti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] angle_rad,
    output logic               out_valid,
    input  logic               out_ready,
    output lookup_t            out_data
);

    logic signed [62:0] product;
    logic [FRAC_W-1:0]  frac_reg;
    logic [FRAC_W-1:0]  frac_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_ready;
    logic [POS_W-1:0]   pos;
    lookup_t            s2_data_reg;
    lookup_t            s2_data_next;
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic               s2_ready;

    assign product   = angle_rad * $signed({1'b0, INV_TWO_PI_Q32});
    assign frac_next = product[FRAC_W-1:0];

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    assign pos = POS_W'(frac_reg[FRAC_W-1:16]) * POS_W'(TABLE_SIZE);

    always_comb
    begin
        s2_data_next.idx    = pos[POS_W-1:40];
        s2_data_next.weight = pos[39:16];
        s2_data_next.turns  = frac_reg[FRAC_W-1:24];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            frac_reg <= frac_next;
        if (s2_ready && s1_valid_reg)
            s2_data_reg <= s2_data_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

// ===== hdl/sti_rom.sv =====
// Stage 3: sine table holding one period in TABLE_SIZE+1 entries, two registered reads
// at the index and the next index. Depends on sti_pkg.
module sti_rom
    import sti_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  lookup_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output pair_t   out_data
);

    localparam sin_rom_t SIN_ROM = build_sin_rom();

    logic [ROM_AW-1:0] addr_lo;
    logic [ROM_AW-1:0] addr_hi;
    pair_t             data_reg;
    logic              valid_reg;
    logic              valid_next;
    logic              ready;

    assign addr_lo = ROM_AW'(in_data.idx);
    assign addr_hi = addr_lo + ROM_AW'(1);

    assign ready      = !valid_reg || out_ready;
    assign in_ready   = ready;
    assign valid_next = ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            data_reg.lo     <= SIN_ROM[addr_lo];
            data_reg.hi     <= SIN_ROM[addr_hi];
            data_reg.weight <= in_data.weight;
            data_reg.turns  <= in_data.turns;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/sti_interp.sv =====
// Stages 4 and 5: weight the two table entries, then sum, round and drive the
// output register. Depends on sti_pkg.
module sti_interp
    import sti_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  pair_t        in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic signed [31:0] sine_value,
    output logic [31:0]  angle_turns
);

    logic [31:0]         ua;
    logic [31:0]         ub;
    logic [WEIGHT_W:0]   weight_lo;
    logic [PROD_W-1:0]   prod_lo_reg;
    logic [PROD_W-1:0]   prod_lo_next;
    logic [PROD_W-1:0]   prod_hi_reg;
    logic [PROD_W-1:0]   prod_hi_next;
    logic [31:0]         turns4_reg;
    logic                s4_valid_reg;
    logic                s4_valid_next;
    logic                s4_ready;
    logic [PROD_W-1:0]   sum;
    logic signed [31:0]  sine_reg;
    logic signed [31:0]  sine_next;
    logic [31:0]         turns_reg;
    logic                s5_valid_reg;
    logic                s5_valid_next;
    logic                s5_ready;

    assign ua        = in_data.lo + SINE_ONE;
    assign ub        = in_data.hi + SINE_ONE;
    assign weight_lo = WEIGHT_ONE - {1'b0, in_data.weight};

    assign prod_lo_next = PROD_W'(ua) * PROD_W'(weight_lo);
    assign prod_hi_next = PROD_W'(ub) * PROD_W'(in_data.weight);

    assign sum       = prod_lo_reg + prod_hi_reg + ROUND_HALF;
    assign sine_next = $signed(sum[WEIGHT_W+31:WEIGHT_W]) - SINE_ONE;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    assign s4_valid_next = s4_ready ? in_valid : s4_valid_reg;
    assign s5_valid_next = s5_ready ? s4_valid_reg : s5_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && in_valid)
        begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            turns4_reg  <= in_data.turns;
        end
        if (s5_ready && s4_valid_reg)
        begin
            sine_reg  <= sine_next;
            turns_reg <= turns4_reg;
        end
    end

    assign out_valid   = s5_valid_reg;
    assign sine_value  = sine_reg;
    assign angle_turns = turns_reg;

endmodule

// ===== hdl/sine_table_interpolator.sv =====
// Sine by table lookup with linear interpolation, plus the angle wrapped to Q31 turns.
// Top level; instantiates sti_turn, sti_rom and sti_interp, depends on sti_pkg.
//
// Input channel: angle_rad (signed Q8.24 radians) with in_valid / in_stall.
// Output channel: sine_value (Q1.30) and angle_turns (Q31, full scale one half
// turn) with out_valid / out_stall. A transfer happens at a rising edge with
// valid high and stall low; each input transfer yields exactly one output.
// Five register stages: turn product, index split, table read, weighting
// products, rounding into the output register. Throughput is one item per
// cycle while out_stall is low: every stage, including the combinational
// 32x31 turn multiplier and the two table read ports, takes a new item each
// cycle. When out_stall is high, the output holds, bubbles ahead of it close
// up, and in_stall rises only once every stage holds an item; nothing is
// lost or repeated. Reset clears all stage valid bits; the table is
// constant and needs no fill time.
module sine_table_interpolator
    import sti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] angle_rad,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sine_value,
    output logic signed [31:0] angle_turns
);

    logic    turn_ready;
    logic    turn_valid;
    lookup_t turn_data;
    logic    rom_ready;
    logic    rom_valid;
    pair_t   rom_data;
    logic    interp_ready;
    logic [31:0] turns_bits;

    sti_turn u_turn
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (turn_ready),
        .angle_rad (angle_rad),
        .out_valid (turn_valid),
        .out_ready (rom_ready),
        .out_data  (turn_data)
    );

    sti_rom u_rom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (turn_valid),
        .in_ready  (rom_ready),
        .in_data   (turn_data),
        .out_valid (rom_valid),
        .out_ready (interp_ready),
        .out_data  (rom_data)
    );

    sti_interp u_interp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rom_valid),
        .in_ready    (interp_ready),
        .in_data     (rom_data),
        .out_valid   (out_valid),
        .out_ready   (!out_stall),
        .sine_value  (sine_value),
        .angle_turns (turns_bits)
    );

    assign in_stall    = !turn_ready;
    assign angle_turns = $signed(turns_bits);

`ifndef SYNTH
    ast_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");

    ast_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_valid && !in_stall, 5) && $past(rst_n, 5) && $past(rst_n, 4)
        && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
        && !$past(out_stall, 4) && !$past(out_stall, 3) && !$past(out_stall, 2)
        && !$past(out_stall, 1)
        |-> out_valid)
        else $error("result missing after unstalled pipeline latency");

    ast_first_half_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !angle_turns[31] |-> sine_value >= 32'sd0 && sine_value <= SINE_ONE)
        else $error("sine out of range for first half turn");

    ast_second_half_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && angle_turns[31] |-> sine_value <= 32'sd0 && sine_value >= -SINE_ONE)
        else $error("sine out of range for second half turn");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for sine_table_interpolator: random and corner angles in,
// sine and wrapped turn angle checked against an in-bench fixed-point predictor.
// Depends on sti_pkg (TABLE_SIZE) and the sine_table_interpolator top level.
module tb_top
    import sti_pkg::*;
();

    localparam logic [63:0]        PI_FIXED_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [63:0] TURN_SCALE   = 64'sd683565276;
    localparam logic [63:0]        ONE_Q30      = 64'd1073741824;
    localparam int                 HALF_PI_Q24  = 26353589;
    localparam int                 KNOT_Q24     = 205887;
    localparam int                 STALL_LIMIT  = 4000;
    localparam int                 HOLD_CYCLES  = 300;
    localparam int                 PHASE_ITEMS  = 435;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_level_t;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] sine;
        logic signed [31:0] turns;
    } sine_result_t;

    class sine_checker;
        logic signed [31:0] knot_q30 [0:TABLE_SIZE];
        sine_result_t       pending_results [$];
        int                 mismatches;

        function new();
            for (int i = 0; i <= TABLE_SIZE; i++)
                knot_q30[i] = knot_sine(i);
            mismatches = 0;
        endfunction

        function logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
            logic [127:0] p;
            p = 128'(a) * 128'(b);
            return 64'(p >> 60);
        endfunction

        function logic signed [31:0] knot_sine(input int i);
            logic [63:0]        n;
            logic [63:0]        q;
            logic [63:0]        den;
            logic [63:0]        x;
            logic [63:0]        x2;
            logic [63:0]        term;
            logic [63:0]        r;
            logic signed [63:0] acc;
            bit                 neg;
            n   = 64'(TABLE_SIZE);
            q   = (64'(i) % n) * 64'd4;
            den = 64'd2 * n;
            neg = 1'b0;
            if (q >= den)
            begin
                neg = 1'b1;
                q   = q - den;
            end
            if (q > n)
                q = den - q;
            x    = (PI_FIXED_Q60 / den) * q + ((PI_FIXED_Q60 % den) * q) / den;
            x2   = q60_product(x, x);
            term = x;
            acc  = $signed(x);
            for (int k = 1; k <= 20; k++)
            begin
                if (term != 64'd0)
                begin
                    term = q60_product(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
                    if (k % 2 == 1)
                        acc = acc - $signed(term);
                    else
                        acc = acc + $signed(term);
                end
            end
            if (acc < 0)
                acc = 64'sd0;
            r = ($unsigned(acc) + 64'd536870912) >> 30;
            if (r > ONE_Q30)
                r = ONE_Q30;
            return neg ? -$signed(r[31:0]) : $signed(r[31:0]);
        endfunction

        function sine_result_t predict(input logic signed [31:0] angle);
            sine_result_t       res;
            logic signed [63:0] prod;
            logic [55:0]        frac;
            logic [63:0]        pos;
            logic [63:0]        f;
            logic [63:0]        idx;
            logic signed [63:0] lo_s;
            logic signed [63:0] hi_s;
            logic [63:0]        v;
            prod      = $signed({{32{angle[31]}}, angle}) * TURN_SCALE;
            frac      = prod[55:0];
            res.angle = angle;
            res.turns = frac[55:24];
            pos       = 64'(frac >> 16) * 64'(TABLE_SIZE);
            idx       = pos >> 40;
            if (idx >= 64'(TABLE_SIZE))
                idx = 64'd0;
            f         = (pos >> 16) & 64'hFFFFFF;
            lo_s      = knot_q30[idx];
            hi_s      = knot_q30[idx + 1];
            lo_s      = lo_s + $signed(ONE_Q30);
            hi_s      = hi_s + $signed(ONE_Q30);
            v         = $unsigned(lo_s) * ((64'd1 << 24) - f) + $unsigned(hi_s) * f;
            v         = ((v + 64'd8388608) >> 24) - ONE_Q30;
            res.sine  = v[31:0];
            return res;
        endfunction

        function void note_angle(input logic signed [31:0] angle);
            pending_results.push_back(predict(angle));
        endfunction

        function void check_result(input logic signed [31:0] sine,
                                   input logic signed [31:0] turns);
            sine_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: sine %0d turns %0d", sine, turns);
                return;
            end
            want = pending_results.pop_front();
            if (want.sine !== sine || want.turns !== turns)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("angle %0d: sine exp %0d got %0d, turns exp %0d got %0d",
                             want.angle, want.sine, sine, want.turns, turns);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic signed [31:0] angle_rad  = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic signed [31:0] sine_value;
    logic signed [31:0] angle_turns;

    sine_checker sb;
    idle_level_t send_level = IDLE_NONE;
    idle_level_t recv_level = IDLE_NONE;
    bit          hold_req   = 1'b0;

    logic signed [31:0] corner_angles [0:21] = '{
        32'sd0, 32'sd1, -32'sd1, 32'h7FFFFFFF, 32'h80000000,
        32'sd52707179, -32'sd52707179, 32'sd26353589, -32'sd26353589,
        32'sd79060768, -32'sd79060768, 32'sd105414357, -32'sd105414357,
        32'sd2108287146, -32'sd2108287146, 32'sd205887, 32'sd205888,
        32'h00FFFFFF, 32'hFF000000, 32'h55555555, 32'hAAAAAAAA, 32'h01000000
    };

    sine_table_interpolator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .angle_rad   (angle_rad),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sine_value  (sine_value),
        .angle_turns (angle_turns)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap(input idle_level_t level);
        int r;
        r = $urandom_range(0, 99);
        if (level == IDLE_NONE)
            return 0;
        if (level == IDLE_LIGHT)
        begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 5);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [31:0] random_angle();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom;
        if (pick < 70)
            return int'($urandom_range(0, 32'h10000000)) - 32'sh08000000;
        if (pick < 90)
            return (int'($urandom_range(0, 162)) - 81) * HALF_PI_Q24
                   + int'($urandom_range(0, 16)) - 8;
        return (int'($urandom_range(0, 20000)) - 10000) * KNOT_Q24
               + int'($urandom_range(0, 8)) - 4;
    endfunction

    task automatic send_angle(input logic signed [31:0] angle);
        int pause;
        pause = pick_gap(send_level);
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid  <= 1'b1;
        angle_rad <= angle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_angle(angle);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input idle_level_t snd, input idle_level_t rcv);
        send_level = snd;
        recv_level = rcv;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_angle(random_angle());
    endtask

    // receiver: check every output transfer, then choose next cycle's stall
    initial
    begin
        int hold_left;
        int r;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(sine_value, angle_turns);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                r = pick_gap(recv_level);
                if (r > 0)
                begin
                    hold_left = r - 1;
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sine_table_interpolator test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_angles[i])
            send_angle(corner_angles[i]);

        run_random(IDLE_LIGHT, IDLE_LIGHT);

        // hold the output while the input keeps offering, then pause until drained
        send_level = IDLE_NONE;
        recv_level = IDLE_NONE;
        hold_req   = 1'b1;
        for (int i = 0; i < 40; i++)
            send_angle(random_angle());
        in_valid <= 1'b0;
        wait_drained();

        run_random(IDLE_NONE, IDLE_NONE);
        run_random(IDLE_HEAVY, IDLE_HEAVY);
        run_random(IDLE_LIGHT, IDLE_HEAVY);

        in_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("sine_table_interpolator test passed");
        else
            $display("sine_table_interpolator test failed");
        $finish;
    end

endmodule
